>>> sv/sema_pkg.sv
package sema_pkg;

  // Memory geometry
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_WORDS = MEM_BYTES / 8;
  localparam int unsigned WIDX_W    = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_CAP   = 32'(MEM_WORDS * 8);

  // Field widths
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned OFS_W  = 32;
  localparam int unsigned DATA_W = 64;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Reset value of the size register
  localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
  localparam logic [1:0] ST_BAD_ALIGN = 2'd2;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_LONG = 2'd3;

  // Alignment masks
  localparam logic [2:0] ALIGN_HALF = 3'h1;
  localparam logic [2:0] ALIGN_WORD = 3'h3;
  localparam logic [2:0] ALIGN_LONG = 3'h7;

  // Classified item handed from front to back
  typedef struct packed {
    logic              is_store;
    logic [1:0]        size;
    logic              big;
    logic [WIDX_W-1:0] widx;
    logic [2:0]        lane;
    logic [1:0]        status;
    logic [DATA_W-1:0] wdata;
  } sema_req_t;

  function automatic logic [DATA_W-1:0] lane_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      SZ_BYTE: m = 64'h0000_0000_0000_00FF;
      SZ_HALF: m = 64'h0000_0000_0000_FFFF;
      SZ_WORD: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Reverse the bytes of a right-aligned value of the given size
  function automatic logic [DATA_W-1:0] swap_bytes(input logic [DATA_W-1:0] v,
                                                   input logic [1:0] size);
    logic [DATA_W-1:0] r;
    case (size)
      SZ_HALF: r = {48'h0, v[7:0], v[15:8]};
      SZ_WORD: r = {32'h0, v[7:0], v[15:8], v[23:16], v[31:24]};
      SZ_LONG: begin
        for (int i = 0; i < 8; i++) begin
          r[8*i +: 8] = v[8*(7-i) +: 8];
        end
      end
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

>>> sv/sema_front.sv
module sema_front (
  input  logic [sema_pkg::CFG_W-1:0]  cfg_size_i,
  input  logic                        req_type_i,
  input  logic [1:0]                  access_size_i,
  input  logic [sema_pkg::OFS_W-1:0]  byte_offset_i,
  input  logic                        big_endian_i,
  input  logic [sema_pkg::DATA_W-1:0] store_data_i,
  output sema_pkg::sema_req_t         req_o
);
  import sema_pkg::*;

  logic [31:0]       size_raw;
  logic [31:0]       size_use;
  logic [2:0]        align_mask;
  logic [DATA_W-1:0] masked;

  // Size in use: multiple of eight, capped at the memory size
  assign size_raw = 32'({cfg_size_i[CFG_W-1:3], 3'b000});
  assign size_use = (size_raw > MEM_CAP) ? MEM_CAP : size_raw;

  always_comb begin
    case (access_size_i)
      SZ_BYTE: align_mask = 3'h0;
      SZ_HALF: align_mask = ALIGN_HALF;
      SZ_WORD: align_mask = ALIGN_WORD;
      default: align_mask = ALIGN_LONG;
    endcase
  end

  assign masked = store_data_i & lane_mask(access_size_i);

  // Classify: address check first, then alignment
  always_comb begin
    req_o.is_store = req_type_i;
    req_o.size     = access_size_i;
    req_o.big      = big_endian_i;
    req_o.widx     = byte_offset_i[3 +: WIDX_W];
    req_o.lane     = byte_offset_i[2:0];
    if (byte_offset_i >= size_use) begin
      req_o.status = ST_BAD_ADDR;
    end else if ((byte_offset_i[2:0] & align_mask) != 3'h0) begin
      req_o.status = ST_BAD_ALIGN;
    end else begin
      req_o.status = ST_OK;
    end
    req_o.wdata = (big_endian_i && access_size_i != SZ_BYTE) ?
                  swap_bytes(masked, access_size_i) : masked;
  end

endmodule

>>> sv/sema_queue.sv
module sema_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  sema_pkg::sema_req_t          push_data_i,
  input  logic                         pop_i,
  output sema_pkg::sema_req_t          head_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [sema_pkg::QCNT_W-1:0]  count_o
);
  import sema_pkg::*;

  sema_req_t         slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign count_o = cnt_q;
  assign head_o  = slot_q[rd_q];

  // Pointer and count update
  always_comb begin
    wr_d  = push_i ? QPTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? QPTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/sema_back.sv
module sema_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sema_pkg::sema_req_t         head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        done_o,
  output logic [sema_pkg::DATA_W-1:0] load_data_o,
  output logic [1:0]                  status_o
);
  import sema_pkg::*;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_DATA  = 2'd2;

  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic [DATA_W-1:0] rdata_q;

  logic [1:0]        state_q, state_d;
  logic [WIDX_W-1:0] clr_q, clr_d;
  sema_req_t         cur_q;
  logic              done_q, done_d;
  logic [DATA_W-1:0] ldata_q, ldata_d;
  logic [1:0]        status_q, status_d;

  logic              we;
  logic [WIDX_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [5:0]        sh;
  logic [DATA_W-1:0] lmask;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] extracted;
  logic [DATA_W-1:0] loaded;

  assign pop_o      = (state_q == B_IDLE) && !empty_i;
  assign clearing_o = (state_q == B_CLEAR);

  // Lane shifting for the current item
  assign sh        = {cur_q.lane, 3'b000};
  assign lmask     = lane_mask(cur_q.size);
  assign merged    = (rdata_q & ~(lmask << sh)) | (cur_q.wdata << sh);
  assign extracted = (rdata_q >> sh) & lmask;
  assign loaded    = (cur_q.big && cur_q.size != SZ_BYTE) ?
                     swap_bytes(extracted, cur_q.size) : extracted;

  // Sequencer: clearing pass, then read and finish each item
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    done_d   = 1'b0;
    ldata_d  = ldata_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = cur_q.widx;
    wdata    = merged;
    case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = WIDX_W'(clr_q + 1'b1);
        if (clr_q == WIDX_W'(MEM_WORDS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_DATA;
        end
      end
      B_DATA: begin
        done_d   = 1'b1;
        status_d = cur_q.status;
        ldata_d  = '0;
        if (cur_q.status == ST_OK) begin
          if (cur_q.is_store) begin
            we = 1'b1;
          end else begin
            ldata_d = loaded;
          end
        end
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ldata_q  <= ldata_d;
    status_q <= status_d;
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // Word memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop_o) begin
      rdata_q <= mem[head_i.widx];
    end
  end

  assign done_o      = done_q;
  assign load_data_o = ldata_q;
  assign status_o    = status_q;

endmodule

>>> sv/sized_endian_memory_access_core.sv
// Byte-addressed RAM of 64-bit little-endian words with 1, 2, 4 or 8 byte loads and
// stores, optionally in big-endian byte order. An item is taken when start_i is high
// and busy_o is low; after reset busy_o stays high while the word memory is cleared
// to zero. Each item gives one result, shown for a single cycle on done_o with
// load_data_o and status_o; the receiver cannot stall it. The back end reads the word
// for an item, then gives the result or does the merged write-back on the single-port
// word memory, and dequeues the next item only after that; a two-entry queue lets the
// front take items while the back end works. An accepted item passes the queue, the
// registered read and the result registers before its result appears. Accesses out of
// range report an invalid address ahead of an alignment fault and leave memory as is.
module sized_endian_memory_access_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        req_type_i,
  input  logic [1:0]                  access_size_i,
  input  logic [sema_pkg::OFS_W-1:0]  byte_offset_i,
  input  logic                        big_endian_i,
  input  logic [sema_pkg::DATA_W-1:0] store_data_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sema_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                        done_o,
  output logic [sema_pkg::DATA_W-1:0] load_data_o,
  output logic [1:0]                  status_o
);
  import sema_pkg::*;

  logic [CFG_W-1:0]  mem_size_q;
  sema_req_t         front_req;
  sema_req_t         head;
  logic              q_empty;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;
  logic              pop;
  logic              clearing;
  logic              accept;

  // Size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mem_size_q <= cfg_wdata_i;
    end
  end

  assign busy_o = clearing || q_full;
  assign accept = start_i && !busy_o;

  sema_front u_front (
    .cfg_size_i    (mem_size_q),
    .req_type_i    (req_type_i),
    .access_size_i (access_size_i),
    .byte_offset_i (byte_offset_i),
    .big_endian_i  (big_endian_i),
    .store_data_i  (store_data_i),
    .req_o         (front_req)
  );

  sema_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_req),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full),
    .count_o     (q_count)
  );

  sema_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .done_o      (done_o),
    .load_data_o (load_data_o),
    .status_o    (status_o)
  );

  // Failed checks never return data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> load_data_o == '0)
    else $error("error result carries data");

  // No result and no dequeue during the clearing pass
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !done_o && !pop)
    else $error("activity during clearing pass");

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH) && !(accept && q_full))
    else $error("queue overflow");

  // A dequeued item yields exactly one result, through the B_DATA state and the done register
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> ##2 done_o)
    else $error("missing result after dequeue");

endmodule

>>> tb/sized_endian_memory_access_core_tb.sv
`timescale 1ns / 100ps

module sized_endian_memory_access_core_tb;
  import sema_pkg::*;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct packed {
    logic [DATA_W-1:0] load_data;
    logic [1:0]        status;
  } access_result_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic              busy_o;
  logic              req_type_i    = REQ_LOAD;
  logic [1:0]        access_size_i = SZ_BYTE;
  logic [OFS_W-1:0]  byte_offset_i = '0;
  logic              big_endian_i  = 1'b0;
  logic [DATA_W-1:0] store_data_i  = '0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              done_o;
  logic [DATA_W-1:0] load_data_o;
  logic [1:0]        status_o;

  // Shadow of the RAM and the size register
  logic [DATA_W-1:0] ram_image [MEM_WORDS];
  logic [CFG_W-1:0]  mem_size_cfg;
  access_result_t    awaited_results [$];

  int unsigned errors      = 0;
  int unsigned n_stores    = 0;
  int unsigned n_loads     = 0;
  int unsigned n_addr_err  = 0;
  int unsigned n_align_err = 0;
  int unsigned n_settings  = 0;
  int unsigned stall_count = 0;
  bit          gaps_on     = 1'b1;

  sized_endian_memory_access_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .access_size_i (access_size_i),
    .byte_offset_i (byte_offset_i),
    .big_endian_i  (big_endian_i),
    .store_data_i  (store_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .load_data_o   (load_data_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Bytes usable: register rounded down to eight, capped at the RAM size
  function automatic logic [31:0] usable_bytes();
    logic [31:0] s;
    s = {{(32-CFG_W){1'b0}}, mem_size_cfg} & ~32'd7;
    if (s > MEM_CAP) s = MEM_CAP;
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] byte_reverse(input logic [DATA_W-1:0] v,
                                                     input int unsigned nbytes);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < nbytes; i++) r = (r << 8) | DATA_W'(v[8*i +: 8]);
    return r;
  endfunction

  // Expected outcome of one access; applies stores to the shadow RAM
  function automatic access_result_t emulate_access(input logic is_store,
                                                    input logic [1:0] sz,
                                                    input logic [OFS_W-1:0] ofs,
                                                    input logic big,
                                                    input logic [DATA_W-1:0] data);
    access_result_t    res;
    int unsigned       nbytes;
    int unsigned       widx;
    int unsigned       shift;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] v;
    nbytes = 1 << sz;
    mask   = (sz == SZ_LONG) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
    res    = '{load_data: '0, status: ST_OK};
    if (ofs >= usable_bytes()) begin
      res.status = ST_BAD_ADDR;
    end else if ((ofs & (nbytes - 1)) != 0) begin
      res.status = ST_BAD_ALIGN;
    end else begin
      widx  = ofs >> 3;
      shift = 8 * ofs[2:0];
      if (is_store) begin
        v = data & mask;
        if (big && nbytes > 1) v = byte_reverse(v, nbytes);
        ram_image[widx] = (ram_image[widx] & ~(mask << shift)) | (v << shift);
      end else begin
        v = (ram_image[widx] >> shift) & mask;
        if (big && nbytes > 1) v = byte_reverse(v, nbytes);
        res.load_data = v;
      end
    end
    return res;
  endfunction

  // Result checking, prediction on acceptance, and the stall watchdog
  always @(posedge clk_i) begin
    access_result_t want;
    access_result_t got;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited, load_data %h status %0d",
                   $time, load_data_o, status_o);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (load_data_o !== want.load_data) begin
            $display("%0t: load_data mismatch, expected %h, actual %h",
                     $time, want.load_data, load_data_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_o);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        got = emulate_access(req_type_i, access_size_i, byte_offset_i, big_endian_i,
                             store_data_i);
        awaited_results.push_back(got);
        if (got.status == ST_BAD_ADDR) n_addr_err++;
        else if (got.status == ST_BAD_ALIGN) n_align_err++;
        else if (req_type_i == REQ_STORE) n_stores++;
        else n_loads++;
      end
      if (cfg_valid_i && cfg_ready_o) mem_size_cfg = cfg_wdata_i;
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one item and hold it until it is sampled with busy_o low
  task automatic send_item(input logic is_store, input logic [1:0] sz,
                           input logic [OFS_W-1:0] ofs, input logic big,
                           input logic [DATA_W-1:0] data);
    if (gaps_on && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    req_type_i    <= is_store;
    access_size_i <= sz;
    byte_offset_i <= ofs;
    big_endian_i  <= big;
    store_data_i  <= data;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Stop issuing and wait for every outstanding result
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mem_size(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [OFS_W-1:0] pick_offset(input logic [1:0] sz);
    logic [31:0] lim;
    logic [31:0] ofs;
    int unsigned roll;
    lim  = usable_bytes();
    roll = $urandom_range(99);
    if (lim == 0 || roll < 5) begin
      ofs = $urandom;
    end else if (roll < 10) begin
      ofs = lim + $urandom_range(0, 15);
    end else begin
      if (roll < 50) ofs = $urandom_range(0, ((lim < 256) ? lim : 256) - 1);
      else if (roll < 60) ofs = lim - 1 - $urandom_range(0, 7);
      else ofs = $urandom_range(0, lim - 1);
      // mostly naturally aligned, a few left as drawn
      if ($urandom_range(99) >= 10) ofs = ofs & ~((32'd1 << sz) - 32'd1);
    end
    return ofs;
  endfunction

  task automatic random_items(input int unsigned count);
    logic [1:0] sz;
    for (int i = 0; i < count; i++) begin
      sz = 2'($urandom_range(0, 3));
      send_item(1'($urandom), sz, pick_offset(sz), 1'($urandom), {$urandom, $urandom});
    end
  endtask

  // Memory must read back as zero after the clearing pass
  task automatic test_cleared_memory();
    send_item(REQ_LOAD, SZ_LONG, 32'd0, 1'b0, '0);
    send_item(REQ_LOAD, SZ_WORD, 32'd4092, 1'b1, '1);
    send_item(REQ_LOAD, SZ_LONG, MEM_CAP - 32'd8, 1'b1, '0);
  endtask

  // Lane placement and byte order for every size
  task automatic test_byte_lanes_and_order();
    send_item(REQ_STORE, SZ_LONG, 32'd16, 1'b0, 64'h0123_4567_89AB_CDEF);
    send_item(REQ_LOAD,  SZ_LONG, 32'd16, 1'b0, '0);
    send_item(REQ_LOAD,  SZ_LONG, 32'd16, 1'b1, '0);
    send_item(REQ_LOAD,  SZ_HALF, 32'd18, 1'b1, '0);
    send_item(REQ_LOAD,  SZ_WORD, 32'd20, 1'b1, '0);
    send_item(REQ_LOAD,  SZ_BYTE, 32'd23, 1'b1, '0);
    // bits above the access size are dropped
    send_item(REQ_STORE, SZ_WORD, 32'd24, 1'b1, 64'hFFFF_FFFF_1122_3344);
    send_item(REQ_STORE, SZ_HALF, 32'd30, 1'b1, 64'hA5A5_A5A5_A5A5_BEEF);
    send_item(REQ_LOAD,  SZ_LONG, 32'd24, 1'b0, '0);
    // byte order flag is a no-op for single bytes
    send_item(REQ_STORE, SZ_BYTE, MEM_CAP - 32'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FF5A);
    send_item(REQ_LOAD,  SZ_BYTE, MEM_CAP - 32'd1, 1'b0, '0);
  endtask

  // Range check takes precedence over alignment
  task automatic test_address_checks();
    send_item(REQ_LOAD,  SZ_HALF, 32'd1, 1'b0, '0);
    send_item(REQ_STORE, SZ_WORD, 32'd2, 1'b1, '1);
    send_item(REQ_STORE, SZ_LONG, 32'd4, 1'b0, '1);
    send_item(REQ_LOAD,  SZ_BYTE, MEM_CAP, 1'b0, '0);
    send_item(REQ_STORE, SZ_LONG, 32'hFFFF_FFFF, 1'b1, '1);
    send_item(REQ_LOAD,  SZ_HALF, 32'hFFFF_FFF9, 1'b0, '0);
  endtask

  // Smallest, zero, unrounded and over-range size settings
  task automatic test_size_settings();
    write_mem_size(CFG_W'(8));
    send_item(REQ_STORE, SZ_LONG, 32'd0, 1'b0, 64'hDEAD_BEEF_CAFE_F00D);
    send_item(REQ_LOAD,  SZ_BYTE, 32'd7, 1'b0, '0);
    send_item(REQ_LOAD,  SZ_BYTE, 32'd8, 1'b0, '0);
    write_mem_size('0);
    send_item(REQ_LOAD,  SZ_BYTE, 32'd0, 1'b0, '0);
    write_mem_size('1);
    send_item(REQ_LOAD,  SZ_LONG, MEM_CAP - 32'd8, 1'b0, '0);
    send_item(REQ_LOAD,  SZ_BYTE, MEM_CAP, 1'b0, '0);
    write_mem_size(CFG_W'(13));
    send_item(REQ_LOAD,  SZ_BYTE, 32'd8, 1'b0, '0);
    send_item(REQ_LOAD,  SZ_LONG, 32'd0, 1'b1, '0);
  endtask

  task automatic test_random_traffic();
    write_mem_size(CFG_RESET);
    random_items(500);
    write_mem_size(CFG_W'($urandom_range(1, 512) * 8));
    random_items(300);
    // back-to-back stretch with no idle cycles
    gaps_on = 1'b0;
    write_mem_size('1);
    random_items(400);
    gaps_on = 1'b1;
    write_mem_size(CFG_W'($urandom_range(0, 131071)));
    random_items(250);
    write_mem_size(CFG_W'(8));
    random_items(100);
    write_mem_size(CFG_W'($urandom_range(0, 131071)));
    random_items(150);
    write_mem_size(CFG_RESET);
    random_items(100);
  endtask

  initial begin
    for (int i = 0; i < MEM_WORDS; i++) ram_image[i] = '0;
    mem_size_cfg = CFG_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cleared_memory();
    test_byte_lanes_and_order();
    test_address_checks();
    test_size_settings();
    test_random_traffic();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d stores and %0d loads in range, %0d address and %0d alignment faults",
             n_stores, n_loads, n_addr_err, n_align_err);
    $display("across %0d size register settings; %0d mismatches", n_settings, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sema_pkg.sv
sv/sema_front.sv
sv/sema_queue.sv
sv/sema_back.sv
sv/sized_endian_memory_access_core.sv
tb/sized_endian_memory_access_core_tb.sv
